[hdl/ciwd_pkg.sv]
// Shared constants, types and helper functions of the CPU idle window detector.
package ciwd_pkg;

   localparam int FRACTION_BITS      = 16;
   localparam int SHARE_W            = FRACTION_BITS + 1;
   localparam int SHARE_ONE          = 1 << FRACTION_BITS;
   localparam int MAX_WINDOW_DEFAULT = 64;

   localparam int CNT_W      = 64;
   localparam int NUM_TERMS  = 8;
   localparam int TERM_IDX_W = $clog2(NUM_TERMS);
   localparam int IDLE_TERM  = 3;
   localparam int REQ_DATA_W = NUM_TERMS * CNT_W;
   localparam int RSP_DATA_W = 40;

   localparam int WLEN_W    = 7;
   localparam int THRESH_W  = 17;
   localparam int TIMEOUT_W = 16;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_IDLE_THRESHOLD = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 2'd2;

   localparam logic [WLEN_W-1:0]    WINDOW_RESET    = 7'd3;
   localparam logic [THRESH_W-1:0]  THRESHOLD_RESET = 17'd52429;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 16'd60;

   typedef enum logic [1:0] {
      WAIT_PENDING = 2'd0,
      WAIT_IDLE    = 2'd1,
      WAIT_TIMEOUT = 2'd2
   } wait_status_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_ACC,
      OP_DELTA,
      OP_CLASSIFY,
      OP_DIV_STEP,
      OP_UPDATE,
      OP_MEAN_START,
      OP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type             op;
      logic [TERM_IDX_W-1:0] term;
   } ctrl_cmd_type;

   typedef struct packed {
      logic have_prev;
      logic out_free;
   } ctrl_stat_type;

   typedef struct packed {
      logic [WLEN_W-1:0]    window_length;
      logic [THRESH_W-1:0]  idle_threshold;
      logic [TIMEOUT_W-1:0] timeout_ticks;
   } csr_cfg_type;

   typedef struct packed {
      logic                 win_clear;
      logic                 tl_load;
      logic [TIMEOUT_W-1:0] tl_value;
   } csr_evt_type;

   // Bits needed for the running window sum at a given ring depth.
   function automatic int sum_width(input int max_window);
      return $clog2(max_window * SHARE_ONE + 1);
   endfunction

   function automatic logic [TIMEOUT_W-1:0] eff_timeout(input logic [TIMEOUT_W-1:0] t);
      return (t == '0) ? TIMEOUT_W'(1) : t;
   endfunction

endpackage

[hdl/cpu_idle_window_detector.sv]
// Top level of the CPU idle window detector.
//
//   channel   direction  handshake             payload
//   req       in         req_tvalid/tready     eight 64-bit cumulative CPU counters
//   rsp       out        rsp_tvalid/tready     status, tick share, window mean, flags
//   csr       in/out     APB psel/penable      window_length, idle_threshold, timeout_ticks
//
// A result is registered after its request has gone through the sum, the share division,
// the update of the default 64-entry ring and the mean division; the next request is
// taken once that result is registered. The load and sum steps add up the counters, then one
// shared 64-bit restoring divider gives one quotient bit per cycle, first for the share and
// then for the window mean. The first request of a measurement skips the divider.
// Reset is synchronous and needs no clearing pass; ring entries are tracked by
// the fill count. A stalled result stays in the output register; the next
// request is taken meanwhile and waits at the end for the register to free.
module cpu_idle_window_detector #(
   parameter int MAX_WINDOW = ciwd_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // user, nice, system, idle, iowait, irq, softirq, steal time; 64 bits each
   input  logic [ciwd_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // wait_status[1:0], sample_share[18:2], sample_valid[19],
   // window_mean[36:20], mean_valid[37], zero pad[39:38]
   output logic [ciwd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ciwd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ciwd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ciwd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import ciwd_pkg::*;

   csr_cfg_type   cfg;
   csr_evt_type   evt;
   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   logic [1:0]         out_status;
   logic [SHARE_W-1:0] out_share;
   logic               out_sv;
   logic [SHARE_W-1:0] out_mean;
   logic               out_mv;

   ciwd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .evt         (evt)
   );

   ciwd_ctrl #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ciwd_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .cfg        (cfg),
      .evt        (evt),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   assign out_status = rsp_tdata[1:0];
   assign out_share  = rsp_tdata[18:2];
   assign out_sv     = rsp_tdata[19];
   assign out_mean   = rsp_tdata[36:20];
   assign out_mv     = rsp_tdata[37];

   // one request in flight: the block is busy right after taking one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while previous one still in work");

   // a full window implies a share was formed this tick
   a_mean_needs_share: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_mv) |-> out_sv)
      else $error("mean valid without sample valid");

   // idle reached only from a valid mean at or above threshold
   a_idle_needs_mean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_status == WAIT_IDLE) |->
         (out_mv && 32'(out_mean) >= 32'(u_csr.cfg.idle_threshold)))
      else $error("idle reached without a qualifying mean");

   // fields without a valid flag read as zero
   a_zero_when_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((out_sv || out_share == '0) && (out_mv || out_mean == '0)))
      else $error("share or mean nonzero while flagged invalid");

endmodule

[hdl/ciwd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ciwd_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/ciwd_csr.sv]
// Configuration register file behind the APB-style port.
module ciwd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ciwd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ciwd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ciwd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output ciwd_pkg::csr_cfg_type               cfg,
   output ciwd_pkg::csr_evt_type               evt
);
   import ciwd_pkg::*;

   logic                 wr_en;
   logic [REG_IDX_W-1:0] reg_idx;
   logic [WLEN_W-1:0]    window_length_ff,  window_length_in;
   logic [THRESH_W-1:0]  idle_threshold_ff, idle_threshold_in;
   logic [TIMEOUT_W-1:0] timeout_ticks_ff,  timeout_ticks_in;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      window_length_in  = window_length_ff;
      idle_threshold_in = idle_threshold_ff;
      timeout_ticks_in  = timeout_ticks_ff;
      evt.win_clear     = 1'b0;
      evt.tl_load       = 1'b0;
      evt.tl_value      = eff_timeout(csr_pwdata[TIMEOUT_W-1:0]);
      csr_prdata        = '0;
      case (reg_idx)
         REG_WINDOW_LENGTH: begin
            csr_prdata = CSR_DATA_W'(window_length_ff);
            if (wr_en) begin
               window_length_in = csr_pwdata[WLEN_W-1:0];
               evt.win_clear    = 1'b1;
            end
         end
         REG_IDLE_THRESHOLD: begin
            csr_prdata = CSR_DATA_W'(idle_threshold_ff);
            if (wr_en) begin
               idle_threshold_in = csr_pwdata[THRESH_W-1:0];
            end
         end
         REG_TIMEOUT_TICKS: begin
            csr_prdata = CSR_DATA_W'(timeout_ticks_ff);
            if (wr_en) begin
               timeout_ticks_in = csr_pwdata[TIMEOUT_W-1:0];
               evt.tl_load      = 1'b1;
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff  <= WINDOW_RESET;
         idle_threshold_ff <= THRESHOLD_RESET;
         timeout_ticks_ff  <= TIMEOUT_RESET;
      end else begin
         window_length_ff  <= window_length_in;
         idle_threshold_ff <= idle_threshold_in;
         timeout_ticks_ff  <= timeout_ticks_in;
      end
   end

   assign cfg.window_length  = window_length_ff;
   assign cfg.idle_threshold = idle_threshold_ff;
   assign cfg.timeout_ticks  = timeout_ticks_ff;

endmodule

[hdl/ciwd_ctrl.sv]
// Sequencer: steps the datapath through sum, share division, ring update and mean.
module ciwd_ctrl #(
   parameter int MAX_WINDOW = ciwd_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  ciwd_pkg::ctrl_stat_type stat,
   output ciwd_pkg::ctrl_cmd_type  cmd
);
   import ciwd_pkg::*;

   localparam int SUM_W  = sum_width(MAX_WINDOW);
   localparam int STEP_W = $clog2(SUM_W);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SUM,
      S_DELTA,
      S_CLASSIFY,
      S_SHARE,
      S_UPDATE,
      S_MEAN_START,
      S_MEAN,
      S_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff,   cnt_in;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd.op     = OP_NONE;
      cmd.term   = cnt_ff[TERM_IDX_W-1:0];
      req_tready = (state_ff == S_IDLE) && !reset;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.op   = OP_LOAD;
               cnt_in   = STEP_W'(1);
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            cmd.op = OP_ACC;
            if (cnt_ff == STEP_W'(NUM_TERMS - 1)) begin
               state_in = S_DELTA;
            end else begin
               cnt_in = cnt_ff + STEP_W'(1);
            end
         end
         S_DELTA: begin
            cmd.op   = OP_DELTA;
            state_in = stat.have_prev ? S_CLASSIFY : S_FINISH;
         end
         S_CLASSIFY: begin
            cmd.op   = OP_CLASSIFY;
            cnt_in   = '0;
            state_in = S_SHARE;
         end
         S_SHARE: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(FRACTION_BITS - 1)) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.op   = OP_UPDATE;
            state_in = S_MEAN_START;
         end
         S_MEAN_START: begin
            cmd.op   = OP_MEAN_START;
            cnt_in   = '0;
            state_in = S_MEAN;
         end
         S_MEAN: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(SUM_W - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold the result until the output register is free
            if (stat.out_free) begin
               cmd.op   = OP_FINISH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[hdl/ciwd_datapath.sv]
// Datapath: counter sum, shared restoring divider, share ring, window sum and tick budget.
module ciwd_datapath #(
   parameter int MAX_WINDOW = ciwd_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ciwd_pkg::ctrl_cmd_type            cmd,
   output ciwd_pkg::ctrl_stat_type           stat,
   input  ciwd_pkg::csr_cfg_type             cfg,
   input  ciwd_pkg::csr_evt_type             evt,
   input  logic [ciwd_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [ciwd_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import ciwd_pkg::*;

   localparam int SUM_W  = sum_width(MAX_WINDOW);
   localparam int FILL_W = $clog2(MAX_WINDOW + 1);
   localparam int POS_W  = $clog2(MAX_WINDOW);

   // control state
   logic                 have_prev_ff,  have_prev_in;
   logic [FILL_W-1:0]    fill_ff,       fill_in;
   logic [POS_W-1:0]     pos_ff,        pos_in;
   logic [SUM_W-1:0]     sum_ff,        sum_in;
   logic [TIMEOUT_W-1:0] ticks_ff,      ticks_in;
   logic                 rsp_valid_ff,  rsp_valid_in;
   logic [CNT_W-1:0]     last_total_ff, last_total_in;
   logic [CNT_W-1:0]     last_idle_ff,  last_idle_in;

   // payload
   logic [REQ_DATA_W-1:0] req_data_ff, req_data_in;
   logic [CNT_W-1:0]      total_ff,    total_in;
   logic [CNT_W-1:0]      rem_ff,      rem_in;
   logic [CNT_W-1:0]      den_ff,      den_in;
   logic [SUM_W-1:0]      quo_ff,      quo_in;
   logic [SUM_W-1:0]      src_ff,      src_in;
   logic                  zero_ff,     zero_in;
   logic                  one_ff,      one_in;
   logic                  full_ff,     full_in;
   logic [SHARE_W-1:0]    share_ff,    share_in;
   wait_status_type       o_status_ff, o_status_in;
   logic [SHARE_W-1:0]    o_share_ff,  o_share_in;
   logic                  o_sv_ff,     o_sv_in;
   logic [SHARE_W-1:0]    o_mean_ff,   o_mean_in;
   logic                  o_mv_ff,     o_mv_in;

   logic [31:0]          wl_ext;
   logic [FILL_W-1:0]    eff_w;
   logic [POS_W-1:0]     pos_eff;
   logic [FILL_W-1:0]    pos_inc;
   logic [CNT_W-1:0]     term;
   logic [CNT_W-1:0]     in_idle;
   logic                 div_top;
   logic [CNT_W-1:0]     div_shift;
   logic                 div_ge;
   logic [SHARE_W-1:0]   share_new;
   logic [SHARE_W-1:0]   ring_old;
   logic                 full_before;
   logic [SUM_W-1:0]     sum_sub;
   logic [FILL_W-1:0]    fill_new;
   logic                 mean_ok;
   logic                 reached;
   logic [TIMEOUT_W-1:0] ticks_dec;
   wait_status_type      status_new;

   always_comb begin
      wl_ext = 32'(cfg.window_length);
      if (wl_ext == 32'd0) begin
         eff_w = FILL_W'(1);
      end else if (wl_ext > 32'(MAX_WINDOW)) begin
         eff_w = FILL_W'(MAX_WINDOW);
      end else begin
         eff_w = FILL_W'(wl_ext);
      end
   end

   assign pos_eff = (FILL_W'(pos_ff) >= eff_w) ? '0 : pos_ff;
   assign pos_inc = FILL_W'(pos_eff) + FILL_W'(1);
   assign term    = req_data_ff[cmd.term * CNT_W +: CNT_W];
   assign in_idle = req_data_ff[IDLE_TERM * CNT_W +: CNT_W];

   // one quotient bit per step; the carry-out bit stands for 2^64 in the remainder
   assign div_top   = rem_ff[CNT_W-1];
   assign div_shift = {rem_ff[CNT_W-2:0], src_ff[SUM_W-1]};
   assign div_ge    = div_top || (div_shift >= den_ff);

   assign share_new   = zero_ff ? '0 : (one_ff ? SHARE_W'(SHARE_ONE) : SHARE_W'(quo_ff));
   assign full_before = (fill_ff >= eff_w);
   assign sum_sub     = full_before ? (sum_ff - SUM_W'(ring_old)) : sum_ff;
   assign fill_new    = full_before ? fill_ff : (fill_ff + FILL_W'(1));

   assign mean_ok    = have_prev_ff && full_ff;
   assign reached    = mean_ok && (quo_ff >= SUM_W'(cfg.idle_threshold));
   assign ticks_dec  = (ticks_ff != '0) ? (ticks_ff - TIMEOUT_W'(1)) : ticks_ff;
   assign status_new = reached ? WAIT_IDLE :
                       ((ticks_dec == '0) ? WAIT_TIMEOUT : WAIT_PENDING);

   ciwd_ram #(
      .WIDTH (SHARE_W),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.op == OP_UPDATE),
      .wr_addr (pos_eff),
      .wr_data (share_new),
      .rd_en   (cmd.op == OP_DELTA),
      .rd_addr (pos_eff),
      .rd_data (ring_old)
   );

   always_comb begin
      have_prev_in  = have_prev_ff;
      fill_in       = fill_ff;
      pos_in        = pos_ff;
      sum_in        = sum_ff;
      ticks_in      = ticks_ff;
      last_total_in = last_total_ff;
      last_idle_in  = last_idle_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      req_data_in   = req_data_ff;
      total_in      = total_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      quo_in        = quo_ff;
      src_in        = src_ff;
      zero_in       = zero_ff;
      one_in        = one_ff;
      full_in       = full_ff;
      share_in      = share_ff;
      o_status_in   = o_status_ff;
      o_share_in    = o_share_ff;
      o_sv_in       = o_sv_ff;
      o_mean_in     = o_mean_ff;
      o_mv_in       = o_mv_ff;
      case (cmd.op)
         OP_LOAD: begin
            req_data_in = req_tdata;
            total_in    = req_tdata[CNT_W-1:0];
         end
         OP_ACC: begin
            total_in = total_ff + term;
         end
         OP_DELTA: begin
            rem_in        = in_idle - last_idle_ff;
            den_in        = total_ff - last_total_ff;
            quo_in        = '0;
            src_in        = '0;
            last_total_in = total_ff;
            last_idle_in  = in_idle;
         end
         OP_CLASSIFY: begin
            zero_in = (den_ff == '0);
            one_in  = (rem_ff >= den_ff);
         end
         OP_DIV_STEP: begin
            rem_in = div_ge ? (div_shift - den_ff) : div_shift;
            quo_in = {quo_ff[SUM_W-2:0], div_ge};
            src_in = {src_ff[SUM_W-2:0], 1'b0};
         end
         OP_UPDATE: begin
            share_in = share_new;
            sum_in   = sum_sub + SUM_W'(share_new);
            fill_in  = fill_new;
            full_in  = (fill_new >= eff_w);
            pos_in   = (pos_inc >= eff_w) ? '0 : POS_W'(pos_inc);
         end
         OP_MEAN_START: begin
            rem_in = '0;
            den_in = CNT_W'(eff_w);
            quo_in = '0;
            src_in = sum_ff;
         end
         OP_FINISH: begin
            rsp_valid_in = 1'b1;
            o_status_in  = status_new;
            o_share_in   = have_prev_ff ? share_ff : '0;
            o_sv_in      = have_prev_ff;
            o_mean_in    = mean_ok ? SHARE_W'(quo_ff) : '0;
            o_mv_in      = mean_ok;
            if (status_new != WAIT_PENDING) begin
               have_prev_in = 1'b0;
               fill_in      = '0;
               pos_in       = '0;
               sum_in       = '0;
               ticks_in     = eff_timeout(cfg.timeout_ticks);
            end else begin
               have_prev_in = 1'b1;
               ticks_in     = ticks_dec;
            end
         end
         default: begin
         end
      endcase
      if (evt.win_clear) begin
         fill_in = '0;
         pos_in  = '0;
         sum_in  = '0;
      end
      if (evt.tl_load) begin
         ticks_in = evt.tl_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff  <= 1'b0;
         fill_ff       <= '0;
         pos_ff        <= '0;
         sum_ff        <= '0;
         ticks_ff      <= eff_timeout(TIMEOUT_RESET);
         rsp_valid_ff  <= 1'b0;
         last_total_ff <= '0;
         last_idle_ff  <= '0;
      end else begin
         have_prev_ff  <= have_prev_in;
         fill_ff       <= fill_in;
         pos_ff        <= pos_in;
         sum_ff        <= sum_in;
         ticks_ff      <= ticks_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_total_ff <= last_total_in;
         last_idle_ff  <= last_idle_in;
      end
   end

   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      total_ff    <= total_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      quo_ff      <= quo_in;
      src_ff      <= src_in;
      zero_ff     <= zero_in;
      one_ff      <= one_in;
      full_ff     <= full_in;
      share_ff    <= share_in;
      o_status_ff <= o_status_in;
      o_share_ff  <= o_share_in;
      o_sv_ff     <= o_sv_in;
      o_mean_ff   <= o_mean_in;
      o_mv_ff     <= o_mv_in;
   end

   assign stat.have_prev = have_prev_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, o_mv_ff, o_mean_ff, o_sv_ff, o_share_ff, o_status_ff};

endmodule

[test/cpu_idle_window_detector_tb.sv]
`timescale 1ns / 1ps
// Testbench for the CPU idle window detector: directed table, then predictor-checked random ticks.
module cpu_idle_window_detector_tb;
   import ciwd_pkg::*;

   localparam int RING_DEPTH   = MAX_WINDOW_DEFAULT;
   localparam int USER_TERM    = 0;
   localparam int DRAIN_CYCLES = 80;
   localparam int PHASES       = 9;
   localparam int PHASE_TICKS  = 160;
   localparam int PRINT_LIMIT  = 60;

   localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

   typedef logic [REQ_DATA_W-1:0] tick_word_type;

   typedef struct packed {
      wait_status_type    status;
      logic [SHARE_W-1:0] share;
      logic               share_valid;
      logic [SHARE_W-1:0] mean;
      logic               mean_valid;
   } tick_result_type;

   typedef enum logic {
      ROW_TICK,
      ROW_WRITE
   } row_kind_type;

   typedef struct {
      row_kind_type           kind;
      tick_word_type          counters;
      bit                     typed;
      tick_result_type        result;
      logic [REG_IDX_W-1:0]   reg_idx;
      logic [CSR_DATA_W-1:0]  value;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   tick_word_type         req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // register copies and measurement state of the predictor
   logic [WLEN_W-1:0]    cfg_window;
   logic [THRESH_W-1:0]  cfg_threshold;
   logic [TIMEOUT_W-1:0] cfg_timeout;
   logic [CNT_W-1:0]     seen_total;
   logic [CNT_W-1:0]     seen_idle;
   bit                   prev_seen;
   logic [SHARE_W-1:0]   share_hist [RING_DEPTH];
   int                   hist_pos;
   int                   hist_fill;
   longint               hist_sum;
   int                   budget_left;

   tick_result_type outcomes_due [$];
   stim_row_type    stim_rows [$];
   tick_word_type   live_counters;
   int              idle_bias = 50;
   bit              no_gaps = 1'b0;
   int              error_count = 0;
   int              ticks_sent = 0;
   int              settings_used = 0;
   int              idle_hits = 0;
   int              timeouts_seen = 0;
   int              full_windows = 0;

   cpu_idle_window_detector u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void check_field(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         if (error_count < PRINT_LIMIT)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
         error_count++;
      end
   endfunction

   function automatic int window_in_use();
      if (cfg_window == 0) return 1;
      if (cfg_window > RING_DEPTH) return RING_DEPTH;
      return int'(cfg_window);
   endfunction

   function automatic void clear_history();
      hist_pos  = 0;
      hist_fill = 0;
      hist_sum  = 0;
   endfunction

   function automatic void restart_measurement();
      prev_seen = 1'b0;
      clear_history();
      budget_left = (cfg_timeout == 0) ? 1 : int'(cfg_timeout);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] cfg_value(input logic [REG_IDX_W-1:0] idx);
      case (idx)
         REG_WINDOW_LENGTH:  return CSR_DATA_W'(cfg_window);
         REG_IDLE_THRESHOLD: return CSR_DATA_W'(cfg_threshold);
         REG_TIMEOUT_TICKS:  return CSR_DATA_W'(cfg_timeout);
         default:            return '0;
      endcase
   endfunction

   function automatic void apply_write(input logic [REG_IDX_W-1:0] idx,
                                       input logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_WINDOW_LENGTH: begin
            cfg_window = value[WLEN_W-1:0];
            clear_history();
         end
         REG_IDLE_THRESHOLD: cfg_threshold = value[THRESH_W-1:0];
         REG_TIMEOUT_TICKS: begin
            cfg_timeout = value[TIMEOUT_W-1:0];
            budget_left = (cfg_timeout == 0) ? 1 : int'(cfg_timeout);
         end
         default: ;
      endcase
   endfunction

   // expected outcome of one tick; advances the predictor state
   function automatic tick_result_type predict_tick(input tick_word_type w);
      tick_result_type                r;
      logic [CNT_W-1:0]               total;
      logic [CNT_W-1:0]               idle;
      logic [CNT_W-1:0]               d_idle;
      logic [CNT_W-1:0]               d_total;
      logic [CNT_W+FRACTION_BITS-1:0] scaled;
      int                             win;
      int                             i;
      r = '0;
      r.status = WAIT_PENDING;
      total = '0;
      for (i = 0; i < NUM_TERMS; i++)
         total += w[i*CNT_W +: CNT_W];
      idle = w[IDLE_TERM*CNT_W +: CNT_W];
      if (prev_seen) begin
         win     = window_in_use();
         d_idle  = idle - seen_idle;
         d_total = total - seen_total;
         if (d_total == 0)
            r.share = '0;
         else if (d_idle >= d_total)
            r.share = SHARE_W'(SHARE_ONE);
         else begin
            scaled  = {d_idle, {FRACTION_BITS{1'b0}}};
            r.share = SHARE_W'(scaled / d_total);
         end
         r.share_valid = 1'b1;
         if (hist_pos >= win) hist_pos = 0;
         if (hist_fill >= win) hist_sum -= share_hist[hist_pos];
         else hist_fill++;
         share_hist[hist_pos] = r.share;
         hist_sum += r.share;
         hist_pos = (hist_pos + 1 >= win) ? 0 : hist_pos + 1;
         if (hist_fill >= win) begin
            r.mean = SHARE_W'(hist_sum / win);
            r.mean_valid = 1'b1;
            if (r.mean >= cfg_threshold) r.status = WAIT_IDLE;
         end
      end
      seen_total = total;
      seen_idle  = idle;
      prev_seen  = 1'b1;
      // reaching idle on the last allowed tick beats the timeout
      if (r.status == WAIT_PENDING) begin
         if (budget_left > 0) budget_left--;
         if (budget_left == 0) r.status = WAIT_TIMEOUT;
      end
      if (r.status != WAIT_PENDING) restart_measurement();
      return r;
   endfunction

   function automatic tick_result_type result_of(input wait_status_type s, input int share,
                                                 input bit sv, input int mean, input bit mv);
      tick_result_type r;
      r.status      = s;
      r.share       = SHARE_W'(share);
      r.share_valid = sv;
      r.mean        = SHARE_W'(mean);
      r.mean_valid  = mv;
      return r;
   endfunction

   function automatic tick_word_type with_term(input tick_word_type w, input int term,
                                               input logic [CNT_W-1:0] v);
      w[term*CNT_W +: CNT_W] = v;
      return w;
   endfunction

   function automatic tick_word_type random_word();
      tick_word_type w;
      int            j;
      for (j = 0; j < REQ_DATA_W / 32; j++)
         w[j*32 +: 32] = $urandom;
      return w;
   endfunction

   function automatic void add_tick(input tick_word_type w);
      stim_row_type row;
      row.kind     = ROW_TICK;
      row.counters = w;
      row.typed    = 1'b0;
      row.result   = '0;
      row.reg_idx  = '0;
      row.value    = '0;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_checked_tick(input tick_word_type w, input tick_result_type r);
      add_tick(w);
      stim_rows[$].typed  = 1'b1;
      stim_rows[$].result = r;
   endfunction

   function automatic void add_write(input logic [REG_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] v);
      stim_row_type row;
      row.kind     = ROW_WRITE;
      row.counters = '0;
      row.typed    = 1'b0;
      row.result   = '0;
      row.reg_idx  = idx;
      row.value    = v;
      stim_rows.push_back(row);
   endfunction

   task automatic csr_access(input bit is_write, input logic [REG_IDX_W-1:0] idx,
                             input logic [CSR_DATA_W-1:0] value,
                             output logic [CSR_DATA_W-1:0] rd);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= is_write ? value : '0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rd = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, idx, v, rd);
      apply_write(idx, v);
      if (idx != REG_UNMAPPED) begin
         csr_access(1'b0, idx, '0, rd);
         check_field("register readback", cfg_value(idx), rd);
      end
   endtask

   task automatic send_tick(input tick_word_type w, input bit typed,
                            input tick_result_type typed_r);
      tick_result_type r;
      while (!no_gaps && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = predict_tick(w);
      outcomes_due.push_back(typed ? typed_r : r);
      ticks_sent++;
   endtask

   // registers change only with the pipeline empty
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // well-formed ticks: counters only grow, idle share follows a drifting bias
   task automatic advance_counters(output tick_word_type w);
      logic [CNT_W-1:0] step;
      bit               frozen;
      int               i;
      if ($urandom_range(11) == 0) idle_bias = $urandom_range(100);
      frozen = ($urandom_range(24) == 0);
      for (i = 0; i < NUM_TERMS; i++) begin
         if (frozen)
            step = '0;
         else if ($urandom_range(39) == 0)
            step = {$urandom, $urandom} >> $urandom_range(63);
         else if (i == IDLE_TERM)
            step = $urandom_range(40 * idle_bias);
         else
            step = $urandom_range(4 * (100 - idle_bias) + 1);
         live_counters[i*CNT_W +: CNT_W] += step;
      end
      w = live_counters;
   endtask

   task automatic random_config();
      logic [CSR_DATA_W-1:0] wlen;
      logic [CSR_DATA_W-1:0] thr;
      logic [CSR_DATA_W-1:0] tmo;
      case ($urandom_range(5))
         0:       wlen = 1;
         1:       wlen = $urandom_range(8, 2);
         2:       wlen = $urandom_range(RING_DEPTH, 1);
         3:       wlen = RING_DEPTH;
         4:       wlen = 0;
         default: wlen = $urandom_range(127, RING_DEPTH + 1);
      endcase
      case ($urandom_range(4))
         0:       thr = 0;
         1:       thr = SHARE_ONE;
         2:       thr = $urandom_range(SHARE_ONE);
         default: thr = $urandom_range(52000, 20000);
      endcase
      case ($urandom_range(4))
         0:       tmo = 0;
         1:       tmo = $urandom_range(8, 1);
         2:       tmo = 65535;
         default: tmo = $urandom_range(100, 10);
      endcase
      wait_drained();
      csr_write(REG_WINDOW_LENGTH, wlen);
      csr_write(REG_IDLE_THRESHOLD, thr);
      csr_write(REG_TIMEOUT_TICKS, tmo);
      settings_used++;
   endtask

   always @(posedge clock)
      rsp_tready <= no_gaps || ($urandom_range(99) >= 30);

   // rsp_tdata: status[1:0], share[18:2], share valid[19], mean[36:20], mean valid[37]
   always @(posedge clock) begin
      tick_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outcomes_due.size() == 0) begin
            if (error_count < PRINT_LIMIT)
               $display("%0t: result with nothing pending: %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = outcomes_due.pop_front();
            check_field("wait_status", want.status, rsp_tdata[1:0]);
            check_field("sample_share", want.share, rsp_tdata[18:2]);
            check_field("sample_valid", want.share_valid, rsp_tdata[19]);
            check_field("window_mean", want.mean, rsp_tdata[36:20]);
            check_field("mean_valid", want.mean_valid, rsp_tdata[37]);
            check_field("pad bits", 0, rsp_tdata[RSP_DATA_W-1:38]);
            if (want.status == WAIT_IDLE) idle_hits++;
            if (want.status == WAIT_TIMEOUT) timeouts_seen++;
            if (want.mean_valid) full_windows++;
         end
      end
   end

   initial begin
      #10_000_000;
      $display("%0t: run stalled, %0d results outstanding", $time, outcomes_due.size());
      $display("cpu_idle_window_detector_tb: FAIL");
      $finish;
   end

   initial begin
      logic [CSR_DATA_W-1:0] rd;
      tick_word_type         w;
      int                    phase;
      int                    n;
      int                    idx;

      cfg_window    = WINDOW_RESET;
      cfg_threshold = THRESHOLD_RESET;
      cfg_timeout   = TIMEOUT_RESET;
      seen_total    = '0;
      seen_idle     = '0;
      restart_measurement();

      // default settings: window 3, threshold ~0.8, 60 ticks
      add_checked_tick('0, result_of(WAIT_PENDING, 0, 0, 0, 0));
      add_checked_tick('0, result_of(WAIT_PENDING, 0, 1, 0, 0));
      add_checked_tick(with_term('0, IDLE_TERM, 100), result_of(WAIT_PENDING, SHARE_ONE, 1, 0, 0));
      add_checked_tick(with_term('0, IDLE_TERM, 200),
                       result_of(WAIT_PENDING, SHARE_ONE, 1, 43690, 1));
      add_checked_tick(with_term('0, IDLE_TERM, 300),
                       result_of(WAIT_IDLE, SHARE_ONE, 1, SHARE_ONE, 1));
      add_checked_tick('1, result_of(WAIT_PENDING, 0, 0, 0, 0));
      // all counters wrap back to zero: idle moved by 1, total by 8
      add_checked_tick('0, result_of(WAIT_PENDING, 8192, 1, 0, 0));
      // user counter runs backwards, idle delta exceeds total delta
      add_checked_tick(with_term(with_term('0, IDLE_TERM, 64'd1000), USER_TERM,
                                 64'hFFFF_FFFF_FFFF_FE0C),
                       result_of(WAIT_PENDING, SHARE_ONE, 1, 0, 0));
      add_write(REG_TIMEOUT_TICKS, 1);
      add_tick({NUM_TERMS{64'hAAAA_AAAA_AAAA_AAAA}});
      add_checked_tick({NUM_TERMS{64'h5555_5555_5555_5555}},
                       result_of(WAIT_TIMEOUT, 0, 0, 0, 0));
      add_write(REG_WINDOW_LENGTH, 0);
      add_write(REG_IDLE_THRESHOLD, 0);
      add_write(REG_TIMEOUT_TICKS, 2);
      add_checked_tick('0, result_of(WAIT_PENDING, 0, 0, 0, 0));
      // idle reached on the last tick of the budget
      add_checked_tick(with_term('0, IDLE_TERM, 50),
                       result_of(WAIT_IDLE, SHARE_ONE, 1, SHARE_ONE, 1));
      add_write(REG_TIMEOUT_TICKS, 0);
      add_checked_tick({NUM_TERMS{64'h5555_5555_5555_5555}},
                       result_of(WAIT_TIMEOUT, 0, 0, 0, 0));
      add_write(REG_WINDOW_LENGTH, 127);
      add_write(REG_IDLE_THRESHOLD, SHARE_ONE);
      add_write(REG_TIMEOUT_TICKS, 65535);
      add_tick('1);
      add_tick('0);
      add_tick({NUM_TERMS{64'hAAAA_AAAA_AAAA_AAAA}});
      add_write(REG_IDLE_THRESHOLD, 17'h1FFFF);
      add_write(REG_UNMAPPED, 32'hFFFF_FFFF);
      add_tick(with_term('0, IDLE_TERM, 64'd12345));
      add_write(REG_WINDOW_LENGTH, WINDOW_RESET);
      add_write(REG_IDLE_THRESHOLD, THRESHOLD_RESET);
      add_write(REG_TIMEOUT_TICKS, TIMEOUT_RESET);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (idx = 0; idx < 3; idx++) begin
         csr_access(1'b0, REG_IDX_W'(idx), '0, rd);
         check_field("register after reset", cfg_value(REG_IDX_W'(idx)), rd);
      end
      settings_used = 1;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_WRITE) begin
            wait_drained();
            csr_write(stim_rows[i].reg_idx, stim_rows[i].value);
            settings_used++;
         end else begin
            send_tick(stim_rows[i].counters, stim_rows[i].typed, stim_rows[i].result);
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         random_config();
         no_gaps = (phase == PHASES / 2);
         live_counters = random_word();
         for (n = 0; n < PHASE_TICKS; n++) begin
            // some requests are unrelated snapshots that break the sequence
            if ($urandom_range(99) < 15)
               w = random_word();
            else
               advance_counters(w);
            send_tick(w, 1'b0, '0);
         end
         no_gaps = 1'b0;
      end

      wait_drained();
      $display("covered %0d ticks under %0d register settings", ticks_sent, settings_used);
      $display("seen %0d idle reached, %0d timed out, %0d full-window means",
               idle_hits, timeouts_seen, full_windows);
      if (error_count == 0)
         $display("cpu_idle_window_detector_tb: PASS");
      else
         $display("cpu_idle_window_detector_tb: FAIL");
      $finish;
   end

endmodule
